>>> hdl/mini_png_stream_parser_defines.svh
// Assertion macros used by the parser back end.
// Both expect signals named clk and rst_n in the calling scope.
`ifndef MINI_PNG_STREAM_PARSER_DEFINES_SVH
`define MINI_PNG_STREAM_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define MPNG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MPNG_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MPNG_ASSERT(lbl, prop, msg)
`define MPNG_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> hdl/mpng_pkg.sv
package mpng_pkg;

    // Largest image dimension is 2**DIM_BITS - 1
    localparam int DIM_BITS = 16;
    localparam int OUT_W    = 16;
    // Width for the D length against width*height compare
    localparam int SIZE_W   = (2 * DIM_BITS > 35) ? 2 * DIM_BITS : 35;

    // Command queue between parser and pixel expander
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // File signature, first byte first
    localparam logic [7:0] MAGIC [8] = '{"M", "i", "n", "i", "-", "P", "N", "G"};
    localparam logic [7:0] TAG_H = "H";
    localparam logic [7:0] TAG_C = "C";
    localparam logic [7:0] TAG_D = "D";
    localparam logic [7:0] TYPE_MAX = 8'd3;

    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_HTAG,
        PH_HLEN,
        PH_HW,
        PH_HH,
        PH_HTYPE,
        PH_CTAG,
        PH_CLEN,
        PH_CDATA,
        PH_DTAG,
        PH_DLEN,
        PH_DDATA,
        PH_FINISH,
        PH_IDLE,
        PH_ERR
    } phase_t;

    typedef enum logic [2:0] {
        KIND_PIXEL   = 3'd0,
        KIND_HEADER  = 3'd1,
        KIND_COMMENT = 3'd2,
        KIND_ERROR   = 3'd3,
        KIND_DONE    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_MAGIC = 3'd0,
        ERR_HTAG  = 3'd1,
        ERR_TYPE  = 3'd2,
        ERR_CTAG  = 3'd3,
        ERR_DTAG  = 3'd4,
        ERR_SIZE  = 3'd5,
        ERR_DIM   = 3'd6
    } err_t;

    // Single result word, or one data byte to expand into pixels
    typedef enum logic {
        OP_SINGLE,
        OP_PIXELS
    } op_t;

    typedef struct packed {
        op_t                 op;
        kind_t               kind;
        logic [7:0]          data;
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
        logic [1:0]          ptype;
        err_t                err;
        logic                restart;   // first data byte: counters start at zero
    } cmd_t;

    typedef struct packed {
        kind_t            kind;
        logic             pixel_value;
        logic [OUT_W-1:0] col;
        logic [OUT_W-1:0] row;
        logic [OUT_W-1:0] image_width;
        logic [OUT_W-1:0] image_height;
        logic [1:0]       pixel_type;
        logic [7:0]       comment_byte;
        err_t             error_code;
        logic             last;
    } res_t;

endpackage

>>> hdl/mpng_in_if.sv
// Byte stream into the parser
interface mpng_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first;

    modport source (output valid, data_byte, first, input ready);
    modport sink   (input valid, data_byte, first, output ready);
endinterface

>>> hdl/mpng_out_if.sv
// Result words out of the parser
interface mpng_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic        pixel_value;
    logic [15:0] col;
    logic [15:0] row;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  pixel_type;
    logic [7:0]  comment_byte;
    logic [2:0]  error_code;
    logic        last;

    modport source (output valid, kind, pixel_value, col, row, image_width, image_height,
                    pixel_type, comment_byte, error_code, last, input ready);
    modport sink   (input valid, kind, pixel_value, col, row, image_width, image_height,
                    pixel_type, comment_byte, error_code, last, output ready);
endinterface

>>> hdl/mini_png_stream_parser.sv
// Mini-PNG stream parser.
// bytes: one file byte per word (data_byte), with first set on the opening byte of a
// file; first restarts the parse from the signature at any time.
// results: one word per event - pixel, header parsed, comment byte, error, image
// complete - with last set on the final word caused by an input byte.
// The parser front takes one byte a cycle while the queue has room and queues a command
// in a four-entry queue; the back end emits one result word a cycle, while results is
// ready, from a registered output. A byte's command passes the queue and then the output
// register. A data byte yields up to eight pixel words and stays at the queue head until
// they are out, so the pixel expander limits the image data rate.
// The input keeps accepting while the queue has room, so bytes that give no result
// flow on while earlier words are still drained.
// Reset: parse restarts at the signature, queue empty, no word valid. There is no
// clearing pass.
// When results is stalled the output word holds, the expander stops, the queue fills
// and bytes.ready falls once it is full.
module mini_png_stream_parser (
    input  logic       clk,
    input  logic       rst_n,
    mpng_in_if.sink    bytes,
    mpng_out_if.source results
);
    import mpng_pkg::*;

    logic push, q_ready, pop, head_valid;
    cmd_t push_cmd, head_cmd;

    mpng_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes),
        .push    (push),
        .cmd     (push_cmd),
        .q_ready (q_ready)
    );

    mpng_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_ready    (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    mpng_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .results    (results)
    );

endmodule

>>> hdl/mpng_front.sv
// Parser front: walks the file structure one byte a cycle while the queue has room and queues commands
module mpng_front (
    input  logic          clk,
    input  logic          rst_n,
    mpng_in_if.sink       bytes,
    output logic          push,
    output mpng_pkg::cmd_t cmd,
    input  logic          q_ready
);
    import mpng_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [31:0]           fc_reg, fc_next;
    logic [31:0]           bl_reg, bl_next;
    logic [DIM_BITS-1:0]   width_reg, width_next;
    logic [DIM_BITS-1:0]   height_reg, height_next;
    logic [1:0]            type_reg, type_next;
    logic [2*DIM_BITS-1:0] area_reg;

    // state as seen by this byte, after a restart if marked first
    phase_t                phase_eff;
    logic [31:0]           fc_eff, bl_eff, fc_inc, shifted;
    logic [DIM_BITS-1:0]   width_eff, height_eff;
    logic [1:0]            type_eff;
    logic                  accept, dim_big, size_bad;

    function automatic cmd_t error_cmd(err_t e);
        cmd_t c;
        c      = '0;
        c.op   = OP_SINGLE;
        c.kind = KIND_ERROR;
        c.err  = e;
        return c;
    endfunction

    function automatic cmd_t done_cmd();
        cmd_t c;
        c      = '0;
        c.op   = OP_SINGLE;
        c.kind = KIND_DONE;
        return c;
    endfunction

    assign bytes.ready = q_ready;
    assign accept      = bytes.valid && q_ready;

    assign phase_eff  = bytes.first ? PH_MAGIC : phase_reg;
    assign fc_eff     = bytes.first ? '0 : fc_reg;
    assign bl_eff     = bytes.first ? '0 : bl_reg;
    assign width_eff  = bytes.first ? '0 : width_reg;
    assign height_eff = bytes.first ? '0 : height_reg;
    assign type_eff   = bytes.first ? '0 : type_reg;

    assign fc_inc   = fc_eff + 32'd1;
    assign shifted  = {bl_eff[23:0], bytes.data_byte};
    assign dim_big  = (shifted >> DIM_BITS) != 32'd0;
    assign size_bad = (SIZE_W'(shifted) << 3) != SIZE_W'(area_reg);

    // parse step
    always_comb
    begin
        phase_next  = phase_eff;
        fc_next     = fc_eff;
        bl_next     = bl_eff;
        width_next  = width_eff;
        height_next = height_eff;
        type_next   = type_eff;
        push        = 1'b0;
        cmd         = '0;
        if (accept)
        begin
            unique case (phase_eff)
                PH_MAGIC:
                begin
                    if (bytes.data_byte != MAGIC[fc_eff[2:0]])
                    begin
                        phase_next = PH_ERR;
                        push       = 1'b1;
                        cmd        = error_cmd(ERR_MAGIC);
                    end
                    else if (fc_eff[2:0] == 3'd7)
                    begin
                        phase_next = PH_HTAG;
                        fc_next    = '0;
                        bl_next    = '0;
                    end
                    else
                    begin
                        fc_next = fc_inc;
                    end
                end
                PH_HTAG, PH_CTAG, PH_DTAG:
                begin
                    priority if (phase_eff == PH_HTAG && bytes.data_byte == TAG_H)
                    begin
                        phase_next = PH_HLEN;
                        fc_next    = '0;
                        bl_next    = '0;
                    end
                    else if (phase_eff == PH_CTAG && bytes.data_byte == TAG_C)
                    begin
                        phase_next = PH_CLEN;
                        fc_next    = '0;
                        bl_next    = '0;
                    end
                    else if (phase_eff == PH_DTAG && bytes.data_byte == TAG_D)
                    begin
                        phase_next = PH_DLEN;
                        fc_next    = '0;
                        bl_next    = '0;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                        push       = 1'b1;
                        priority if (phase_eff == PH_HTAG)
                            cmd = error_cmd(ERR_HTAG);
                        else if (phase_eff == PH_CTAG)
                            cmd = error_cmd(ERR_CTAG);
                        else
                            cmd = error_cmd(ERR_DTAG);
                    end
                end
                PH_HLEN, PH_HW, PH_HH, PH_CLEN, PH_DLEN:
                begin
                    bl_next = shifted;
                    fc_next = fc_inc;
                    // fourth byte completes the 32-bit field
                    if (fc_eff[1:0] == 2'd3)
                    begin
                        unique case (phase_eff)
                            PH_HLEN:
                            begin
                                phase_next = PH_HW;
                                fc_next    = '0;
                                bl_next    = '0;
                            end
                            PH_HW, PH_HH:
                            begin
                                if (dim_big)
                                begin
                                    phase_next = PH_ERR;
                                    push       = 1'b1;
                                    cmd        = error_cmd(ERR_DIM);
                                end
                                else if (phase_eff == PH_HW)
                                begin
                                    width_next = shifted[DIM_BITS-1:0];
                                    phase_next = PH_HH;
                                    fc_next    = '0;
                                    bl_next    = '0;
                                end
                                else
                                begin
                                    height_next = shifted[DIM_BITS-1:0];
                                    phase_next  = PH_HTYPE;
                                    fc_next     = '0;
                                    bl_next     = '0;
                                end
                            end
                            PH_CLEN:
                            begin
                                fc_next    = '0;
                                phase_next = (shifted == 32'd0) ? PH_DTAG : PH_CDATA;
                            end
                            default:
                            begin
                                // D length
                                fc_next = '0;
                                if (type_eff == 2'd1 && size_bad)
                                begin
                                    phase_next = PH_ERR;
                                    push       = 1'b1;
                                    cmd        = error_cmd(ERR_SIZE);
                                end
                                else if (shifted == 32'd0)
                                begin
                                    phase_next = PH_IDLE;
                                    push       = 1'b1;
                                    cmd        = done_cmd();
                                end
                                else
                                begin
                                    phase_next = PH_DDATA;
                                end
                            end
                        endcase
                    end
                end
                PH_HTYPE:
                begin
                    push = 1'b1;
                    if (bytes.data_byte > TYPE_MAX)
                    begin
                        phase_next = PH_ERR;
                        cmd        = error_cmd(ERR_TYPE);
                    end
                    else
                    begin
                        type_next  = bytes.data_byte[1:0];
                        phase_next = PH_CTAG;
                        cmd.op     = OP_SINGLE;
                        cmd.kind   = KIND_HEADER;
                        cmd.width  = width_eff;
                        cmd.height = height_eff;
                        cmd.ptype  = bytes.data_byte[1:0];
                    end
                end
                PH_CDATA:
                begin
                    push     = 1'b1;
                    cmd.op   = OP_SINGLE;
                    cmd.kind = KIND_COMMENT;
                    cmd.data = bytes.data_byte;
                    fc_next  = fc_inc;
                    if (fc_inc >= bl_eff)
                    begin
                        phase_next = PH_DTAG;
                        fc_next    = '0;
                        bl_next    = '0;
                    end
                end
                PH_DDATA:
                begin
                    push        = 1'b1;
                    cmd.op      = OP_PIXELS;
                    cmd.kind    = KIND_PIXEL;
                    cmd.data    = bytes.data_byte;
                    cmd.width   = width_eff;
                    cmd.height  = height_eff;
                    cmd.restart = (fc_eff == 32'd0);
                    fc_next     = fc_inc;
                    if (fc_inc >= bl_eff)
                        phase_next = PH_FINISH;
                end
                PH_FINISH:
                begin
                    phase_next = PH_IDLE;
                    push       = 1'b1;
                    cmd        = done_cmd();
                end
                default:
                begin
                    // idle or stopped on error: wait for a restart
                end
            endcase
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            fc_reg     <= '0;
            bl_reg     <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            type_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            fc_reg     <= fc_next;
            bl_reg     <= bl_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            type_reg   <= type_next;
        end
    end

    // image area, settled long before the D length arrives
    always_ff @(posedge clk)
    begin
        area_reg <= (2*DIM_BITS)'(width_reg) * (2*DIM_BITS)'(height_reg);
    end

endmodule

>>> hdl/mpng_queue.sv
// Small command queue between parser and pixel expander
module mpng_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mpng_pkg::cmd_t push_cmd,
    output logic           q_ready,
    input  logic           pop,
    output logic           head_valid,
    output mpng_pkg::cmd_t head_cmd
);
    import mpng_pkg::*;

    cmd_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign q_ready    = count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && q_ready;
    assign do_pop     = pop && head_valid;

    // pointer update, depth is a power of two
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

>>> hdl/mpng_back.sv
`include "mini_png_stream_parser_defines.svh"

// Back end: turns commands into result words, one word a cycle while results is ready
module mpng_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  mpng_pkg::cmd_t head_cmd,
    output logic           pop,
    mpng_out_if.source     results
);
    import mpng_pkg::*;

    logic [2:0]          bit_idx_reg, bit_idx_next;
    logic [DIM_BITS-1:0] col_reg, col_next;
    logic [DIM_BITS-1:0] row_reg, row_next;
    logic                out_valid_reg, out_valid_next;
    res_t                res_reg, res_next;

    logic                out_ld, load, fresh, wrap, stop, in_image;
    logic [DIM_BITS-1:0] cur_col, cur_row;
    logic [DIM_BITS:0]   col_inc, row_inc;

    assign out_ld = !out_valid_reg || results.ready;

    // pixel position for the current bit
    assign fresh    = head_cmd.restart && bit_idx_reg == 3'd0;
    assign cur_col  = fresh ? '0 : col_reg;
    assign cur_row  = fresh ? '0 : row_reg;
    assign in_image = cur_row < head_cmd.height;
    assign col_inc  = {1'b0, cur_col} + 1'b1;
    assign wrap     = col_inc >= {1'b0, head_cmd.width};
    assign row_inc  = {1'b0, cur_row} + (DIM_BITS+1)'(wrap);
    assign stop     = row_inc >= {1'b0, head_cmd.height};

    // command execution
    always_comb
    begin
        bit_idx_next = bit_idx_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        res_next     = res_reg;
        pop          = 1'b0;
        load         = 1'b0;
        if (head_valid && out_ld)
        begin
            unique case (head_cmd.op)
                OP_SINGLE:
                begin
                    load                  = 1'b1;
                    pop                   = 1'b1;
                    res_next              = '0;
                    res_next.kind         = head_cmd.kind;
                    res_next.last         = 1'b1;
                    if (head_cmd.kind == KIND_HEADER)
                    begin
                        res_next.image_width  = OUT_W'(head_cmd.width);
                        res_next.image_height = OUT_W'(head_cmd.height);
                        res_next.pixel_type   = head_cmd.ptype;
                    end
                    if (head_cmd.kind == KIND_COMMENT)
                        res_next.comment_byte = head_cmd.data;
                    if (head_cmd.kind == KIND_ERROR)
                        res_next.error_code = head_cmd.err;
                end
                OP_PIXELS:
                begin
                    if (!in_image)
                    begin
                        // image already full: byte gives nothing
                        pop          = 1'b1;
                        bit_idx_next = '0;
                        col_next     = cur_col;
                        row_next     = cur_row;
                    end
                    else
                    begin
                        load                 = 1'b1;
                        res_next             = '0;
                        res_next.kind        = KIND_PIXEL;
                        res_next.pixel_value = head_cmd.data[3'd7 - bit_idx_reg];
                        res_next.col         = OUT_W'(cur_col);
                        res_next.row         = OUT_W'(cur_row);
                        res_next.last        = (bit_idx_reg == 3'd7) || stop;
                        col_next             = wrap ? '0 : col_inc[DIM_BITS-1:0];
                        row_next             = row_inc[DIM_BITS-1:0];
                        if ((bit_idx_reg == 3'd7) || stop)
                        begin
                            pop          = 1'b1;
                            bit_idx_next = '0;
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        out_valid_next = load ? 1'b1 : (out_ld ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_idx_reg   <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bit_idx_reg   <= bit_idx_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.kind         = res_reg.kind;
    assign results.pixel_value  = res_reg.pixel_value;
    assign results.col          = res_reg.col;
    assign results.row          = res_reg.row;
    assign results.image_width  = res_reg.image_width;
    assign results.image_height = res_reg.image_height;
    assign results.pixel_type   = res_reg.pixel_type;
    assign results.comment_byte = res_reg.comment_byte;
    assign results.error_code   = res_reg.error_code;
    assign results.last         = res_reg.last;

    // a byte part-way through expansion stays at the head
    `MPNG_ASSERT(a_idx_head, (bit_idx_reg != 3'd0) |-> (head_valid && head_cmd.op == OP_PIXELS), "bit index set without pixel command")
    // a command leaves only when the output slot is free
    `MPNG_ASSERT(a_pop_slot, pop |-> out_ld, "command popped while output stalled")
    // the next command always starts at its first bit
    `MPNG_ASSERT_NEXT(a_idx_clear, pop, bit_idx_reg == 3'd0, "bit index not cleared after pop")
    // non-pixel words close their byte
    `MPNG_ASSERT(a_single_last, (out_valid_reg && res_reg.kind != KIND_PIXEL) |-> res_reg.last, "non-pixel word without last")

endmodule
